FILE: src/irod_pkg.sv
// Package for the IR obstacle calibrating detector.
// Shared types, opcodes and controller command/status structs. No dependencies.
package irod_pkg;

    localparam int OP_BITS = 2;
    localparam int SAMPLE_BITS = 12;

    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_START_CAL = 2'd1,
        OP_RESET_CAL = 2'd2,
        OP_SET_THR   = 2'd3
    } op_t;

    localparam logic [1:0] REG_DEF_THR  = 2'd0;
    localparam logic [1:0] REG_AUTO_CAL = 2'd1;
    localparam logic [1:0] REG_EXP_CAL  = 2'd2;
    localparam logic [1:0] REG_STAB_LIM = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_STAT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic update;     // apply the item to the state registers
        logic stat_clr;   // clear window accumulator
        logic stat_step;  // accumulate one history entry
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic out_load;   // load result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic stat_done;
        logic div_done;
    } ctrl_sts_t;

endpackage

FILE: src/irod_ctrl.sv
// Controller state machine of the IR obstacle detector.
// Depends on irod_pkg.
module irod_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_free,
    input  irod_pkg::ctrl_sts_t sts,
    output irod_pkg::ctrl_cmd_t cmd,
    output logic                busy
);

    irod_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= irod_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            irod_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    state_next = irod_pkg::ST_UPDATE;
                end
            end
            irod_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                cmd.stat_clr = 1'b1;
                state_next = irod_pkg::ST_STAT;
            end
            irod_pkg::ST_STAT: begin
                cmd.stat_step = 1'b1;
                if (sts.stat_done) begin
                    cmd.div_start = 1'b1;
                    state_next = irod_pkg::ST_DIV;
                end
            end
            irod_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = irod_pkg::ST_OUT;
                end
            end
            irod_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = irod_pkg::ST_IDLE;
                end
            end
            default: state_next = irod_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: src/irod_datapath.sv
// Datapath of the IR obstacle detector: state registers, window statistics,
// restoring divider for distance. Depends on irod_pkg.
module irod_datapath #(
    parameter int WINDOW_LEN  = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_fire,
    input  logic [1:0]             in_op,
    input  logic [11:0]            in_value,
    input  irod_pkg::ctrl_cmd_t    cmd,
    output irod_pkg::ctrl_sts_t    sts,
    output logic [47:0]            result
);

    localparam int SB   = irod_pkg::SAMPLE_BITS;
    localparam int PB   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUMW = SB + $clog2(WINDOW_LEN + 1);
    localparam int SQW  = 2 * SB + $clog2(WINDOW_LEN + 1);
    localparam int CMPW = SQW + 8;
    localparam int QB   = 15;
    localparam logic [SB-1:0] SMAX = {SB{1'b1}};
    localparam logic [PB-1:0] PLAST = PB'(WINDOW_LEN - 1);

    // configuration
    logic [11:0] def_thr_reg;
    logic [7:0]  auto_cal_reg;
    logic [9:0]  exp_cal_reg;
    logic [15:0] stab_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_thr_reg  <= 12'd500;
            auto_cal_reg <= 8'd100;
            exp_cal_reg  <= 10'd200;
            stab_lim_reg <= 16'd100;
        end else if (cfg_we) begin
            case (cfg_addr)
                irod_pkg::REG_DEF_THR:  def_thr_reg  <= cfg_wdata[11:0];
                irod_pkg::REG_AUTO_CAL: auto_cal_reg <= cfg_wdata[7:0];
                irod_pkg::REG_EXP_CAL:  exp_cal_reg  <= cfg_wdata[9:0];
                default:                stab_lim_reg <= cfg_wdata;
            endcase
        end
    end

    // captured item
    logic [1:0]    op_reg;
    logic [SB-1:0] val_reg;
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= in_op;
            val_reg <= in_value[SB-1:0];
        end
    end

    // block state
    logic [SB-1:0] thr_reg, last_reg, min_reg, max_reg;
    logic          cal_reg, run_reg, obs_reg;
    logic [7:0]    auto_reg;
    logic [9:0]    runc_reg;
    logic [SB-1:0] hist_reg [WINDOW_LEN];
    logic [PB-1:0] pos_reg;

    logic [SB-1:0] mn, mx, spn;
    logic [9:0]    rc1;
    logic [7:0]    ac1;
    logic [SB+2:0] four_d;
    logic [SB+18:0] fifth_prod;
    logic [SB-1:0] fifth;

    // floor(x/5) as (x * 52429) >> 18, exact for x below 2^16
    always_comb begin
        mn = (val_reg < min_reg) ? val_reg : min_reg;
        mx = (val_reg > max_reg) ? val_reg : max_reg;
        spn = mx - mn;
        four_d = {1'b0, spn, 2'b00};
        fifth_prod = (SB+19)'(four_d) * (SB+19)'(16'd52429);
        fifth = fifth_prod[18 +: SB];
        rc1 = runc_reg + 10'd1;
        ac1 = (auto_reg == 8'd255) ? auto_reg : auto_reg + 8'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= SB'(12'd500);
            last_reg <= '0;
            min_reg  <= SMAX;
            max_reg  <= '0;
            cal_reg  <= 1'b0;
            run_reg  <= 1'b0;
            obs_reg  <= 1'b0;
            auto_reg <= '0;
            runc_reg <= '0;
            pos_reg  <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) hist_reg[i] <= '0;
        end else if (cmd.update) begin
            unique case (op_reg)
                irod_pkg::OP_SAMPLE: begin
                    last_reg <= val_reg;
                    hist_reg[pos_reg] <= val_reg;
                    pos_reg <= (pos_reg == PLAST) ? '0 : pos_reg + PB'(1);
                    if (run_reg) begin
                        min_reg <= mn;
                        max_reg <= mx;
                        runc_reg <= rc1;
                        if (rc1 >= exp_cal_reg || rc1 == 10'd0) begin
                            thr_reg <= mn + fifth;
                            cal_reg <= 1'b1;
                            run_reg <= 1'b0;
                        end
                    end else begin
                        if (!cal_reg) begin
                            min_reg <= mn;
                            max_reg <= mx;
                            auto_reg <= ac1;
                            if (ac1 >= auto_cal_reg) cal_reg <= 1'b1;
                        end
                        obs_reg <= val_reg > thr_reg;
                    end
                end
                irod_pkg::OP_START_CAL: begin
                    min_reg <= SMAX;
                    max_reg <= '0;
                    cal_reg <= 1'b0;
                    run_reg <= 1'b1;
                    runc_reg <= '0;
                end
                irod_pkg::OP_RESET_CAL: begin
                    min_reg <= SMAX;
                    max_reg <= '0;
                    cal_reg <= 1'b0;
                    thr_reg <= def_thr_reg[SB-1:0];
                    run_reg <= 1'b0;
                    runc_reg <= '0;
                end
                default: thr_reg <= val_reg;
            endcase
        end
    end

    // window statistics, one entry per cycle
    logic [PB-1:0]   sidx_reg;
    logic [SUMW-1:0] sum_reg, sum_fin;
    logic [SQW-1:0]  sq_reg, sq_fin;
    logic [2*SB-1:0] sqr;
    assign sqr = hist_reg[sidx_reg] * hist_reg[sidx_reg];
    // sums including the entry read this cycle
    assign sum_fin = sum_reg + SUMW'(hist_reg[sidx_reg]);
    assign sq_fin  = sq_reg + SQW'(sqr);

    always_ff @(posedge aclk) begin
        if (cmd.stat_clr) begin
            sidx_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end else if (cmd.stat_step) begin
            sidx_reg <= (sidx_reg == PLAST) ? sidx_reg : sidx_reg + PB'(1);
            sum_reg  <= sum_fin;
            sq_reg   <= sq_fin;
        end
    end
    assign sts.stat_done = cmd.stat_step && (sidx_reg == PLAST);

    // stable compare, registered in two steps via divide phase
    logic [CMPW-1:0] wsq_reg, s2_reg, lim_reg;
    logic            stable_reg;
    logic [CMPW-1:0] var_w;
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            wsq_reg <= CMPW'(sq_fin) * CMPW'(WINDOW_LEN);
            s2_reg  <= CMPW'(sum_fin) * CMPW'(sum_fin);
            lim_reg <= CMPW'(stab_lim_reg) * CMPW'(WINDOW_LEN * WINDOW_LEN);
        end
    end
    assign var_w = wsq_reg - s2_reg;
    always_ff @(posedge aclk) begin
        if (cmd.div_step) stable_reg <= var_w < lim_reg;
    end

    // distance: floor(25600*(max-s)/(max-min)), restoring divider
    logic          dvalid;
    logic [SB-1:0] dnum, dden;
    assign dvalid = cal_reg && (max_reg > min_reg);
    assign dnum = max_reg - last_reg;
    assign dden = max_reg - min_reg;

    localparam int NUMW = SB + QB;
    logic [NUMW-1:0] num_reg;
    logic [SB:0]     rem_reg;
    logic [QB-1:0]   q_reg;
    logic [SB-1:0]   den_reg;
    logic [4:0]      cnt_reg;
    logic [1:0]      dmode_reg; // 0 zero, 1 full, 2 divide
    logic [SB:0]     rsh, rsub;

    assign rsh  = {rem_reg[SB-1:0], num_reg[NUMW-1]};
    assign rsub = rsh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg <= NUMW'(dnum) * NUMW'(25600);
            rem_reg <= '0;
            q_reg   <= '0;
            den_reg <= dden;
            cnt_reg <= 5'(NUMW - 1);
            if (!dvalid || last_reg >= max_reg) dmode_reg <= 2'd0;
            else if (last_reg <= min_reg)       dmode_reg <= 2'd1;
            else                                dmode_reg <= 2'd2;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            cnt_reg <= cnt_reg - 5'd1;
            if (!rsub[SB]) begin
                rem_reg <= rsub;
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end else begin
                rem_reg <= rsh;
                q_reg   <= {q_reg[QB-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = cmd.div_step && (cnt_reg == 5'd0);

    logic [QB-1:0] dist_q;
    always_comb begin
        case (dmode_reg)
            2'd0:    dist_q = '0;
            2'd1:    dist_q = 15'd25600;
            default: dist_q = q_reg;
        endcase
    end

    // stable is sampled on each divide step from the registered compare; holds till output
    assign result = {4'b0, stable_reg, dvalid, dist_q, 12'(thr_reg), run_reg, cal_reg,
                     12'(last_reg), obs_reg};

endmodule

FILE: src/ir_obstacle_calibrating_detector.sv
// Top level of the IR obstacle calibrating detector.
// Depends on irod_pkg, irod_ctrl and irod_datapath.
//
// Takes one item at a time (operation, value) and returns one result item
// per input: obstacle flag, last sample, calibration status, threshold,
// distance in Q7.8 cm and a window stability flag. Samples are 12 bits wide.
// From acceptance to result an item passes through the update state, one
// window-sum step per history entry, the restoring divider (one step per
// numerator bit) and the load of the result register, which waits while
// the output is stalled. The result register decouples the output; the
// next item is accepted only after the previous result is loaded into it.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
module ir_obstacle_calibrating_detector #(
    parameter int WINDOW_LEN  = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] operation, [13:2] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // obstacle, last_sample[12], calibrated,
                                   // calibrating, threshold_now[12],
                                   // distance[15], distance_valid, stable
);

    irod_pkg::ctrl_cmd_t cmd;
    irod_pkg::ctrl_sts_t sts;
    logic        busy, in_fire, out_free;
    logic [47:0] result;
    logic        mvalid_reg;
    logic [47:0] mdata_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    irod_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .out_free(out_free),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    irod_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_fire  (in_fire),
        .in_op    (s_tdata[1:0]),
        .in_value (s_tdata[13:2]),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) mdata_reg <= result;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

FILE: src/irod_checker.sv
// Port-level checker for the IR obstacle detector, bound to the top level.
// Depends on ir_obstacle_calibrating_detector ports only.
module irod_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted two items back to back");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[41:27] <= 15'd25600)
        else $error("distance out of range");

    a_dist_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[42] |-> m_tdata[41:27] == 15'd0)
        else $error("invalid distance not zero");

endmodule

bind ir_obstacle_calibrating_detector irod_checker u_irod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: verif/tb_top.sv
// Self-checking testbench for ir_obstacle_calibrating_detector.
// Needs irod_pkg and the detector RTL. A directed table runs first, then random
// phases that change the configuration and the idle and stall patterns.
`timescale 1ns / 1ps

module tb_top;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RAND_PER_PHASE = 200;
    localparam int  SETTLE_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 1000000;

    // Result item layout, lowest bit last.
    typedef struct packed {
        logic [3:0]  pad;
        logic        stable;
        logic        dist_valid;
        logic [14:0] distance;
        logic [11:0] threshold;
        logic        calibrating;
        logic        calibrated;
        logic [11:0] last_sample;
        logic        obstacle;
    } result_t;

    typedef struct {
        irod_pkg::op_t op;
        logic [11:0] value;
        bit          typed;      // expected result given in the row
        result_t     exp_res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;        // [1:0] operation, [13:2] value
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;        // see result_t

    ir_obstacle_calibrating_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Predictor state and its copy of the configuration.
    logic [11:0] cfg_def_thr;
    logic [7:0]  cfg_auto;
    logic [9:0]  cfg_explicit;
    logic [15:0] cfg_stab;
    logic [11:0] thr_reg, last_smp, rng_min, rng_max;
    logic        cal_done, run_on, obst;
    logic [7:0]  auto_cnt;
    logic [9:0]  run_cnt;
    logic [11:0] win [5];
    int          win_pos;

    result_t     expected_results [$];
    int          mismatches;
    int          results_seen;
    longint      cycles;
    bit          sender_idle, receiver_stall;
    int          idle_pct;       // idle or stall chance in percent

    function automatic void track_range(logic [11:0] s);
        if (s < rng_min) rng_min = s;
        if (s > rng_max) rng_max = s;
    endfunction

    // Applies one item to the predicted state and returns the result it gives.
    function automatic result_t predict_detector(irod_pkg::op_t op, logic [11:0] v);
        result_t r;
        longint  sum, sumsq, num;
        int      span;
        sum = 0;
        sumsq = 0;
        case (op)
            irod_pkg::OP_SAMPLE: begin
                last_smp = v;
                win[win_pos] = v;
                win_pos = (win_pos == 4) ? 0 : win_pos + 1;
                if (run_on) begin
                    track_range(v);
                    run_cnt = run_cnt + 10'd1;
                    // a zero count or a wrap ends the run at once
                    if (run_cnt >= cfg_explicit || run_cnt == 10'd0) begin
                        span = int'(rng_max) - int'(rng_min);
                        thr_reg = 12'(int'(rng_min) + (4 * span) / 5);
                        cal_done = 1'b1;
                        run_on = 1'b0;
                    end
                end else begin
                    if (!cal_done) begin
                        track_range(v);
                        if (auto_cnt < 8'd255) auto_cnt = auto_cnt + 8'd1;
                        if (auto_cnt >= cfg_auto) cal_done = 1'b1;
                    end
                    obst = v > thr_reg;
                end
            end
            irod_pkg::OP_START_CAL: begin
                rng_min = 12'hFFF;
                rng_max = 12'h000;
                cal_done = 1'b0;
                run_on = 1'b1;
                run_cnt = '0;
            end
            irod_pkg::OP_RESET_CAL: begin
                cal_done = 1'b0;
                rng_min = 12'hFFF;
                rng_max = 12'h000;
                thr_reg = cfg_def_thr;
                run_on = 1'b0;
                run_cnt = '0;
            end
            default: thr_reg = v;
        endcase
        r = '0;
        r.obstacle    = obst;
        r.last_sample = last_smp;
        r.calibrated  = cal_done;
        r.calibrating = run_on;
        r.threshold   = thr_reg;
        r.dist_valid  = cal_done && (rng_max > rng_min);
        if (r.dist_valid) begin
            if (last_smp >= rng_max) r.distance = '0;
            else if (last_smp <= rng_min) r.distance = 15'd25600;
            else r.distance = 15'((longint'(25600) * (rng_max - last_smp)) /
                                  longint'(rng_max - rng_min));
        end
        for (int i = 0; i < 5; i++) begin
            sum += win[i];
            sumsq += longint'(win[i]) * win[i];
        end
        num = 5 * sumsq - sum * sum;
        r.stable = num < 25 * longint'(cfg_stab);
        return r;
    endfunction

    // Offers one item, possibly after a random gap, and waits for acceptance.
    task automatic send_item(irod_pkg::op_t op, logic [11:0] v, bit typed,
                             result_t typed_res);
        result_t p;
        if (sender_idle && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        p = predict_detector(op, v);
        expected_results.push_back(typed ? typed_res : p);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, v, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Drives one register write; the caller drops cfg_we after the last one.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            irod_pkg::REG_DEF_THR:  cfg_def_thr  = val[11:0];
            irod_pkg::REG_AUTO_CAL: cfg_auto     = val[7:0];
            irod_pkg::REG_EXP_CAL:  cfg_explicit = val[9:0];
            default:                cfg_stab     = val;
        endcase
    endtask

    // Mostly samples; clustered values give stable windows, extremes hit clamps.
    task automatic random_item(ref logic [11:0] base);
        int sel;
        irod_pkg::op_t op;
        logic [11:0] v;
        sel = $urandom_range(99);
        if (sel < 80) op = irod_pkg::OP_SAMPLE;
        else if (sel < 87) op = irod_pkg::OP_START_CAL;
        else if (sel < 93) op = irod_pkg::OP_RESET_CAL;
        else op = irod_pkg::OP_SET_THR;
        sel = $urandom_range(99);
        if (sel < 10) base = 12'($urandom());
        if (sel < 45) v = 12'(int'(base) + $urandom_range(6) - 3);
        else if (sel < 55) v = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
        else v = 12'($urandom());
        send_item(op, v, 1'b0, '0);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        result_t act, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            act = result_t'(m_tdata);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (act.obstacle !== exp_r.obstacle || act.last_sample !== exp_r.last_sample
                    || act.calibrated !== exp_r.calibrated
                    || act.calibrating !== exp_r.calibrating
                    || act.threshold !== exp_r.threshold || act.distance !== exp_r.distance
                    || act.dist_valid !== exp_r.dist_valid || act.stable !== exp_r.stable
                    || act.pad !== 4'h0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"item %0d: exp obs=%b smp=%0d cal=%b run=%b thr=%0d ",
                                  "dist=%0d dv=%b stb=%b / got obs=%b smp=%0d cal=%b ",
                                  "run=%b thr=%0d dist=%0d dv=%b stb=%b pad=%h"},
                                 results_seen, exp_r.obstacle, exp_r.last_sample,
                                 exp_r.calibrated, exp_r.calibrating, exp_r.threshold,
                                 exp_r.distance, exp_r.dist_valid, exp_r.stable,
                                 act.obstacle, act.last_sample, act.calibrated,
                                 act.calibrating, act.threshold, act.distance,
                                 act.dist_valid, act.stable, act.pad);
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge aclk) begin
        m_tready <= receiver_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        stim_row_t   rows [$];
        stim_row_t   row;
        logic [11:0] base;
        int          phase;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sender_idle = 1'b0;
        receiver_stall = 1'b0;
        idle_pct = 72;
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        base = 12'd2000;

        // predictor reset state
        cfg_def_thr = 12'd500;
        cfg_auto = 8'd100;
        cfg_explicit = 10'd200;
        cfg_stab = 16'd100;
        thr_reg = 12'd500;
        last_smp = '0;
        rng_min = 12'hFFF;
        rng_max = '0;
        cal_done = 1'b0;
        run_on = 1'b0;
        obst = 1'b0;
        auto_cnt = '0;
        run_cnt = '0;
        foreach (win[i]) win[i] = '0;
        win_pos = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at the reset configuration.
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd0, 1'b1,
                         '{4'h0, 1'b1, 1'b0, 15'd0, 12'd500, 1'b0, 1'b0, 12'd0, 1'b0}});
        rows.push_back('{irod_pkg::OP_SET_THR, 12'hFFF, 1'b1,
                         '{4'h0, 1'b1, 1'b0, 15'd0, 12'hFFF, 1'b0, 1'b0, 12'd0, 1'b0}});
        rows.push_back('{irod_pkg::OP_RESET_CAL, 12'hABC, 1'b1,
                         '{4'h0, 1'b1, 1'b0, 15'd0, 12'd500, 1'b0, 1'b0, 12'd0, 1'b0}});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'hFFF, 1'b1,
                         '{4'h0, 1'b0, 1'b0, 15'd0, 12'd500, 1'b0, 1'b0, 12'hFFF, 1'b1}});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd500, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd501, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_START_CAL, 12'h555, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd100, 1'b0, '0});   // obstacle held in run
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd3000, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SET_THR, 12'd1234, 1'b0, '0}); // set threshold in run
        rows.push_back('{irod_pkg::OP_START_CAL, 12'd0, 1'b0, '0});  // restart while running
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'hAAA, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_RESET_CAL, 12'd0, 1'b0, '0});  // abort run
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'h555, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'h555, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SET_THR, 12'd0, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd1, 1'b0, '0});
        rows.push_back('{irod_pkg::OP_SAMPLE, 12'd0, 1'b0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.op, row.value, row.typed, row.exp_res);
        end

        // Random phases: each sets new registers, then a new idle pattern.
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(irod_pkg::REG_DEF_THR, 16'd0);
                    write_reg(irod_pkg::REG_AUTO_CAL, 16'd1);
                    write_reg(irod_pkg::REG_EXP_CAL, 16'd1);
                    write_reg(irod_pkg::REG_STAB_LIM, 16'd0);
                end
                1: begin
                    write_reg(irod_pkg::REG_DEF_THR, 16'd4095);
                    write_reg(irod_pkg::REG_AUTO_CAL, 16'd255);
                    write_reg(irod_pkg::REG_EXP_CAL, 16'd1023);
                    write_reg(irod_pkg::REG_STAB_LIM, 16'hFFFF);
                end
                2: begin
                    write_reg(irod_pkg::REG_DEF_THR, 16'($urandom_range(4095)));
                    write_reg(irod_pkg::REG_AUTO_CAL, 16'($urandom_range(20, 1)));
                    write_reg(irod_pkg::REG_EXP_CAL, 16'($urandom_range(30, 1)));
                    write_reg(irod_pkg::REG_STAB_LIM, 16'($urandom_range(65535)));
                end
                default: begin
                    // zero counts: calibrate and end runs on the first sample
                    write_reg(irod_pkg::REG_DEF_THR, 16'($urandom_range(4095)));
                    write_reg(irod_pkg::REG_AUTO_CAL, 16'd0);
                    write_reg(irod_pkg::REG_EXP_CAL, 16'd0);
                    write_reg(irod_pkg::REG_STAB_LIM, 16'($urandom_range(2000)));
                end
            endcase
            cfg_we <= 1'b0;
            sender_idle    = (phase == 1) || (phase == 3);
            receiver_stall = (phase == 2) || (phase == 3);
            idle_pct       = (phase == 3) ? 25 : 72;
            repeat (RAND_PER_PHASE) random_item(base);
        end

        wait_drained();
        $display("ran %0d result items over a directed table and 4 random phases", results_seen);
        $display("register extremes, zero counts, aborted and restarted runs; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
